// ===== design/cfc_pkg.sv =====
// Shared widths, status codes, pipeline side-band type and saturation helpers
// for the circle-from-three-points pipeline. No dependencies.
package cfc_pkg;

    // coordinate width (signed fixed point, raw codes)
    localparam int CW   = 32;
    // point difference, product of two differences, sum of two squares
    localparam int DW   = CW + 1;
    localparam int MW   = 2 * DW;
    localparam int SW   = MW;
    // half of a sum of squares, fed to one partial product
    localparam int HW   = DW;
    localparam int PPW  = DW + HW + 1;
    // bisector numerator, doubled determinant
    localparam int NW   = DW + SW + 1;
    localparam int EW   = MW + 2;
    // divider operands and remainder
    localparam int NPW  = NW + 1;
    localparam int DPW  = EW + 1;
    localparam int RW   = DPW + 1;
    localparam int CMPW = DPW + CW + 1;
    // quotient magnitude, signed offset, center and quadrant sums
    localparam int QW   = CW + 1;
    localparam int OW   = CW + 2;
    localparam int CXW  = CW + 3;
    localparam int QUW  = CW + 4;
    // square root operand, root and remainder
    localparam int SQW  = 2 * QW + 1;
    localparam int RTW  = CW + 1;
    localparam int TW   = SQW + 2;

    // unit latencies
    localparam int DIV_LAT  = QW + 2;
    localparam int SQRT_LAT = RTW + 1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COLIN = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    // data that rides along the pipeline next to the arithmetic
    typedef struct packed {
        logic                  vld;
        logic                  colin;
        logic signed [CXW-1:0] cx;
        logic signed [CXW-1:0] cy;
        logic signed [CW-1:0]  z;
    } t_side;

    // true when v does not fit the signed coordinate range
    function automatic logic f_ovf(input logic signed [QUW-1:0] v);
        logic [QUW-CW:0] top;
        top = v[QUW-1:CW-1];
        return !((&top) || (~|top));
    endfunction

    // clamp v to the signed coordinate range
    function automatic logic signed [CW-1:0] f_sat(input logic signed [QUW-1:0] v);
        logic signed [CW-1:0] res;
        if (f_ovf(v)) begin
            res = v[QUW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/circle_from_three_points_unit.sv =====
// Circle through three points: center, radius and quadrant extremes.
// Throughput: one word per cycle while the output is not stalled; the pipe
// depth is set by the pipelined divider (35 stages with load and clamp) and
// square root (34 stages with rounding). A stall on the output freezes every stage.
// Reset clears the valid bits only. Depends on cfc_pkg, cfc_div, cfc_sqrt.
module circle_from_three_points_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [cfc_pkg::CW-1:0] i_first_x,
    input  logic signed [cfc_pkg::CW-1:0] i_first_y,
    input  logic signed [cfc_pkg::CW-1:0] i_second_x,
    input  logic signed [cfc_pkg::CW-1:0] i_second_y,
    input  logic signed [cfc_pkg::CW-1:0] i_third_x,
    input  logic signed [cfc_pkg::CW-1:0] i_third_y,
    input  logic signed [cfc_pkg::CW-1:0] i_plane_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic signed [cfc_pkg::CW-1:0] o_center_x,
    output logic signed [cfc_pkg::CW-1:0] o_center_y,
    output logic [cfc_pkg::CW-2:0]        o_circle_radius,
    output logic signed [cfc_pkg::CW-1:0] o_left_x,
    output logic signed [cfc_pkg::CW-1:0] o_right_x,
    output logic signed [cfc_pkg::CW-1:0] o_top_y,
    output logic signed [cfc_pkg::CW-1:0] o_bottom_y,
    output logic signed [cfc_pkg::CW-1:0] o_quadrant_z
);
    import cfc_pkg::*;

    localparam int P_DIVIN  = 6;
    localparam int P_DIVOUT = P_DIVIN + DIV_LAT;
    localparam int P_CEN    = P_DIVOUT + 1;
    localparam int P_SUM    = P_CEN + 1;
    localparam int P_ROOT   = P_SUM + SQRT_LAT;

    logic  w_en;
    t_side r_side [0:P_ROOT];

    logic signed [DW-1:0]  r1_bx, r1_by, r1_qx, r1_qy;
    logic signed [DW-1:0]  r2_bx, r2_by, r2_qx, r2_qy;
    logic signed [MW-1:0]  r_p_bq, r_p_bqx, r_p_bb, r_p_yy, r_p_xx, r_p_qq;
    logic signed [DW-1:0]  r3_bx, r3_by, r3_qx, r3_qy;
    logic signed [MW:0]    r3_det, r4_det, r5_det, r6_det;
    logic [SW-1:0]         r_bsq, r_csq;
    logic signed [PPW-1:0] r_pa_l, r_pa_h, r_pb_l, r_pb_h;
    logic signed [PPW-1:0] r_pc_l, r_pc_h, r_pd_l, r_pd_h;
    logic signed [NW-1:0]  r_a, r_b, r_c, r_d;
    logic signed [NW-1:0]  r_nx, r_ny;
    logic [MW:0]           n_adet;
    logic [NW-1:0]         n_anx, n_any;
    logic [NPW-1:0]        r_numx, r_numy;
    logic [DPW-1:0]        r_den;
    logic                  r_negx, r_negy;
    logic signed [OW-1:0]  w_ux, w_uy;
    logic [QW-1:0]         n_mx, n_my;
    logic [2*QW-1:0]       r_sqx, r_sqy;
    logic [SQW-1:0]        r_sum;
    logic [RTW-1:0]        w_root;

    logic signed [QUW-1:0] n_cx, n_cy, n_rad, n_lx, n_rx, n_ty, n_by;
    logic                  n_rsat, n_any_sat;

    logic                  r_out_vld;
    t_status               r_status;
    logic signed [CW-1:0]  r_cx, r_cy, r_lx, r_rx, r_ty, r_by, r_z;
    logic [CW-2:0]         r_rad;

    // the whole pipe moves unless a finished word is held by the sink
    assign w_en    = !r_out_vld || !i_stall;
    assign o_stall = !w_en;

    // side-band chain: valid, collinear flag, running center, z level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= P_ROOT; i++) begin
                r_side[i].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_side[0].vld   <= i_valid;
            r_side[0].colin <= 1'b0;
            r_side[0].cx    <= CXW'(i_first_x);
            r_side[0].cy    <= CXW'(i_first_y);
            r_side[0].z     <= i_plane_z;
            for (int i = 1; i <= P_ROOT; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_side[2].colin  <= (r_p_bq == r_p_bqx);
            r_side[P_CEN].cx <= r_side[P_CEN-1].cx + CXW'(w_ux);
            r_side[P_CEN].cy <= r_side[P_CEN-1].cy + CXW'(w_uy);
        end
    end

    // stage 1: edge vectors from the first point
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_bx <= DW'(i_second_x) - DW'(i_first_x);
            r1_by <= DW'(i_second_y) - DW'(i_first_y);
            r1_qx <= DW'(i_third_x) - DW'(i_first_x);
            r1_qy <= DW'(i_third_y) - DW'(i_first_y);
        end
    end

    // stage 2: cross and square products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_bq  <= r1_bx * r1_qy;
            r_p_bqx <= r1_by * r1_qx;
            r_p_bb  <= r1_bx * r1_bx;
            r_p_yy  <= r1_by * r1_by;
            r_p_xx  <= r1_qx * r1_qx;
            r_p_qq  <= r1_qy * r1_qy;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_qx   <= r1_qx;
            r2_qy   <= r1_qy;
        end
    end

    // stage 3: determinant and squared edge lengths
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_det <= (MW+1)'(r_p_bq) - (MW+1)'(r_p_bqx);
            r_bsq  <= SW'(r_p_bb) + SW'(r_p_yy);
            r_csq  <= SW'(r_p_xx) + SW'(r_p_qq);
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;
            r3_qx  <= r2_qx;
            r3_qy  <= r2_qy;
        end
    end

    // stage 4: partial products against the low and high halves
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa_l <= r3_qy * $signed({1'b0, r_bsq[HW-1:0]});
            r_pa_h <= r3_qy * $signed({1'b0, r_bsq[SW-1:HW]});
            r_pb_l <= r3_by * $signed({1'b0, r_csq[HW-1:0]});
            r_pb_h <= r3_by * $signed({1'b0, r_csq[SW-1:HW]});
            r_pc_l <= r3_bx * $signed({1'b0, r_csq[HW-1:0]});
            r_pc_h <= r3_bx * $signed({1'b0, r_csq[SW-1:HW]});
            r_pd_l <= r3_qx * $signed({1'b0, r_bsq[HW-1:0]});
            r_pd_h <= r3_qx * $signed({1'b0, r_bsq[SW-1:HW]});
            r4_det <= r3_det;
        end
    end

    // stage 5: assemble full products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a    <= (NW'(r_pa_h) <<< HW) + NW'(r_pa_l);
            r_b    <= (NW'(r_pb_h) <<< HW) + NW'(r_pb_l);
            r_c    <= (NW'(r_pc_h) <<< HW) + NW'(r_pc_l);
            r_d    <= (NW'(r_pd_h) <<< HW) + NW'(r_pd_l);
            r5_det <= r4_det;
        end
    end

    // stage 6: bisector numerators
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx   <= r_a - r_b;
            r_ny   <= r_c - r_d;
            r6_det <= r5_det;
        end
    end

    // stage 7: magnitudes with rounding term, signs of the quotients
    assign n_adet = r6_det[MW] ? (MW+1)'(-r6_det) : (MW+1)'(r6_det);
    assign n_anx  = r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
    assign n_any  = r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_numx <= NPW'({n_anx, 1'b0}) + NPW'({n_adet, 1'b0});
            r_numy <= NPW'({n_any, 1'b0}) + NPW'({n_adet, 1'b0});
            r_den  <= DPW'({n_adet, 2'b00});
            r_negx <= r_nx[NW-1] != r6_det[MW];
            r_negy <= r_ny[NW-1] != r6_det[MW];
        end
    end

    cfc_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_numx),
        .i_den  (r_den),
        .i_neg  (r_negx),
        .o_quot (w_ux)
    );

    cfc_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_numy),
        .i_den  (r_den),
        .i_neg  (r_negy),
        .o_quot (w_uy)
    );

    // square the offsets, then add
    assign n_mx = w_ux[OW-1] ? QW'(-w_ux) : QW'(w_ux);
    assign n_my = w_uy[OW-1] ? QW'(-w_uy) : QW'(w_uy);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx <= n_mx * n_mx;
            r_sqy <= n_my * n_my;
            r_sum <= SQW'(r_sqx) + SQW'(r_sqy);
        end
    end

    cfc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sum  (r_sum),
        .o_root (w_root)
    );

    // quadrant extremes from the unsaturated center and radius
    always_comb begin
        n_cx      = QUW'(r_side[P_ROOT].cx);
        n_cy      = QUW'(r_side[P_ROOT].cy);
        n_rad     = $signed(QUW'(w_root));
        n_lx      = n_cx - n_rad;
        n_rx      = n_cx + n_rad;
        n_ty      = n_cy + n_rad;
        n_by      = n_cy - n_rad;
        n_rsat    = |w_root[RTW-1:CW-1];
        n_any_sat = f_ovf(n_cx) || f_ovf(n_cy) || n_rsat || f_ovf(n_lx)
                 || f_ovf(n_rx) || f_ovf(n_ty) || f_ovf(n_by);
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_side[P_ROOT].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_side[P_ROOT].colin) begin
                r_status <= ST_COLIN;
                r_cx     <= '0;
                r_cy     <= '0;
                r_rad    <= '0;
                r_lx     <= '0;
                r_rx     <= '0;
                r_ty     <= '0;
                r_by     <= '0;
                r_z      <= '0;
            end else begin
                r_status <= n_any_sat ? ST_SAT : ST_OK;
                r_cx     <= f_sat(n_cx);
                r_cy     <= f_sat(n_cy);
                r_rad    <= n_rsat ? {(CW-1){1'b1}} : w_root[CW-2:0];
                r_lx     <= f_sat(n_lx);
                r_rx     <= f_sat(n_rx);
                r_ty     <= f_sat(n_ty);
                r_by     <= f_sat(n_by);
                r_z      <= r_side[P_ROOT].z;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_status        = r_status;
    assign o_center_x      = r_cx;
    assign o_center_y      = r_cy;
    assign o_circle_radius = r_rad;
    assign o_left_x        = r_lx;
    assign o_right_x       = r_rx;
    assign o_top_y         = r_ty;
    assign o_bottom_y      = r_by;
    assign o_quadrant_z    = r_z;

endmodule

// ===== design/cfc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, with clamp and sign.
// Depends on cfc_pkg.
module cfc_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cfc_pkg::NPW-1:0]       i_num,
    input  logic [cfc_pkg::DPW-1:0]       i_den,
    input  logic                          i_neg,
    output logic signed [cfc_pkg::OW-1:0] o_quot
);
    import cfc_pkg::*;

    logic [RW-1:0]  r_rem [0:QW];
    logic [QW-1:0]  r_num [0:QW];
    logic [QW-1:0]  r_quo [0:QW];
    logic [DPW-1:0] r_den [0:QW];
    logic           r_neg [0:QW];
    logic           r_ovf [0:QW];
    logic signed [OW-1:0] r_quot;
    logic [QW-1:0]  n_mag;

    // detect a quotient above the clamp limit, load the top of the dividend
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num >> QW);
            r_num[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= CMPW'(i_num) >= (CMPW'({i_den, {CW{1'b0}}}) + CMPW'(i_den));
        end
    end

    // one restoring step per stage
    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int B = QW - k;
        logic [RW-1:0] n_try;
        logic          n_ge;
        assign n_try = {r_rem[k-1][RW-2:0], r_num[k-1][B]};
        assign n_ge  = n_try >= RW'(r_den[k-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_try - RW'(r_den[k-1]) : n_try;
                r_quo[k] <= {r_quo[k-1][QW-2:0], n_ge};
                r_num[k] <= r_num[k-1];
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    // clamp and apply sign
    assign n_mag = r_ovf[QW] ? {1'b1, {(QW-1){1'b0}}} : r_quo[QW];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= r_neg[QW] ? -$signed(OW'(n_mag)) : $signed(OW'(n_mag));
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== design/cfc_sqrt.sv =====
// Pipelined rounded integer square root, one root bit per stage.
// Depends on cfc_pkg.
module cfc_sqrt (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [cfc_pkg::SQW-1:0]  i_sum,
    output logic [cfc_pkg::RTW-1:0]  o_root
);
    import cfc_pkg::*;

    logic [TW-1:0]  r_rem  [1:RTW];
    logic [RTW-1:0] r_root [1:RTW];
    logic [RTW-1:0] r_out;

    // try one root bit per stage, top bit first; the first stage takes the operand
    for (genvar k = 1; k <= RTW; k++) begin : g_bit
        localparam int B = RTW - k;
        logic [TW-1:0]  n_rem;
        logic [RTW-1:0] n_root;
        logic [TW-1:0]  n_test;
        if (k == 1) begin : g_first
            assign n_rem  = TW'(i_sum);
            assign n_root = '0;
        end else begin : g_next
            assign n_rem  = r_rem[k-1];
            assign n_root = r_root[k-1];
        end
        assign n_test = (TW'(n_root) << (B + 1)) | (TW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_rem >= n_test) begin
                    r_rem[k]  <= n_rem - n_test;
                    r_root[k] <= n_root | (RTW'(1) << B);
                end else begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                end
            end
        end
    end

    // round to nearest: bump when the remainder exceeds the root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= (r_rem[RTW] > TW'(r_root[RTW])) ? r_root[RTW] + RTW'(1) : r_root[RTW];
        end
    end

    assign o_root = r_out;

endmodule
